FILE: sv/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int SizeW = 21;
  localparam int NeedW = 22;
  localparam int LgW   = 4;
  localparam int PadW  = 16;

  typedef logic [SizeW-1:0] size_t;

  localparam size_t      PoolLimit   = 21'd1048576;
  localparam size_t      InitSizeRst = 21'd4096;
  localparam size_t      MaxSizeRst  = 21'd0;
  localparam logic [7:0] MarginRst   = 8'd40;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_NOT_FOUND  = 2'd2
  } status_e;

  localparam logic [1:0] CfgInitSize   = 2'd0;
  localparam logic [1:0] CfgMaxSize    = 2'd1;
  localparam logic [1:0] CfgSplitMargin = 2'd2;

endpackage
`default_nettype wire

FILE: sv/ffba_align.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_align
// Rounds a block start up to a power-of-two boundary and gives the padding.
// ----------------------------------------------------------------------------
module ffba_align #(
  parameter int AW = 20
) (
  input  wire logic [AW-1:0]              start_i,
  input  wire logic [ffba_pkg::LgW-1:0]   lg_i,
  output logic      [AW+ffba_pkg::PadW-1:0] aligned_o,
  output logic      [ffba_pkg::PadW-1:0]  pad_o
);
  import ffba_pkg::*;

  logic [PadW:0]      one_sh;
  logic [PadW-1:0]    mask;
  logic [AW+PadW-1:0] sum;
  logic [AW+PadW-1:0] diff;

  always_comb begin
    one_sh    = (PadW+1)'(1) << lg_i;
    mask      = PadW'(one_sh - (PadW+1)'(1));
    sum       = {{PadW{1'b0}}, start_i} + {{AW{1'b0}}, mask};
    aligned_o = sum & ~{{AW{1'b0}}, mask};
    diff      = aligned_o - {{PadW{1'b0}}, start_i};
    pad_o     = diff[PadW-1:0];
  end

endmodule
`default_nettype wire

FILE: sv/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over an address-ordered block table with alignment,
// splitting, pool growth and coalescing of free neighbors on free.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+----------------
//  request | func_i request_size_i alignment_log2_i address_i | start & !busy
//  result  | address_out_o status_o used_bytes_o total_bytes_o| done_o strobe
//  config  | cfg_idx_i cfg_data_i                             | cfg_we_i
//
// Every scan, shift or compaction step visits one table entry as a read
// state followed by an evaluate/write state, since the block table is a
// memory with one write port and a registered read port.
// A zero-size allocate goes straight to done_o with ST_ALLOC_FAIL.
// After reset, and after a write of initial_size, S_INIT rebuilds entry 0.
// Results cannot be stalled; done_o is high for one cycle per transaction.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        func_i,
  input  wire ffba_pkg::size_t             request_size_i,
  input  wire logic [ffba_pkg::LgW-1:0]    alignment_log2_i,
  input  wire logic [ADDR_BITS-1:0]        address_i,
  output logic                             done_o,
  output logic [ADDR_BITS-1:0]             address_out_o,
  output logic [1:0]                       status_o,
  output ffba_pkg::size_t                  used_bytes_o,
  output ffba_pkg::size_t                  total_bytes_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire ffba_pkg::size_t             cfg_data_i
);
  import ffba_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = ADDR_BITS + PadW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_EV = 4'd3;
  localparam logic [3:0] S_SH_RD   = 4'd4;
  localparam logic [3:0] S_SH_WR   = 4'd5;
  localparam logic [3:0] S_WR_REM  = 4'd6;
  localparam logic [3:0] S_WR_HIT  = 4'd7;
  localparam logic [3:0] S_GROW1   = 4'd8;
  localparam logic [3:0] S_GROW2   = 4'd9;
  localparam logic [3:0] S_FIND_RD = 4'd10;
  localparam logic [3:0] S_FIND_EV = 4'd11;
  localparam logic [3:0] S_CO_RD   = 4'd12;
  localparam logic [3:0] S_CO_EV   = 4'd13;
  localparam logic [3:0] S_CO_END  = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    size_t                size;
    logic                 used;
    logic [LgW-1:0]       lg;
  } entry_t;

  // block table
  entry_t mem [MAX_BLOCKS];
  entry_t rdata_q;
  logic   mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata;

  logic [3:0]  state_q;
  size_t       init_size_q, max_size_q, pool_q, used_q, room_q, req_size_q;
  logic [7:0]  margin_q;
  logic [LgW-1:0] lg_q;
  logic [ADDR_BITS-1:0] addr_q, al_q;
  logic [CW-1:0] count_q, idx_q, k_q, w_q, fidx_q;
  logic        retry_q, split_q, func_q;
  logic [NeedW-1:0] need_q;
  entry_t      cur_q, acc_q;
  logic [1:0]  res_status_q;
  logic [ADDR_BITS-1:0] res_addr_q;

  // shared alignment unit
  logic [LgW-1:0] al_lg;
  logic [XW-1:0]  al_full;
  logic [PadW-1:0] al_pad;

  assign al_lg = (state_q == S_FIND_EV) ? rdata_q.lg : lg_q;

  ffba_align #(.AW(ADDR_BITS)) u_align (
    .start_i   (rdata_q.start),
    .lg_i      (al_lg),
    .aligned_o (al_full),
    .pad_o     (al_pad)
  );

  logic [NeedW-1:0] need_c;
  logic             fit_c, split_c;
  logic [NeedW:0]   need_margin_c;
  logic [ADDR_BITS+NeedW-1:0] rem_start_c;
  logic [ADDR_BITS+SizeW-1:0] pool_ext_c;
  entry_t           co_e;
  logic             merge_c;
  logic [NeedW-1:0] twice_c;
  size_t            lim_c, amt_c, clamp_c;
  logic [CW-1:0]    idx_inc;

  always_comb begin
    need_c        = NeedW'(req_size_q) + NeedW'(al_pad);
    fit_c         = !rdata_q.used && (NeedW'(rdata_q.size) >= need_c);
    need_margin_c = (NeedW+1)'(need_c) + (NeedW+1)'(margin_q);
    split_c       = ((NeedW+1)'(rdata_q.size) > need_margin_c) &&
                    (count_q < CW'(MAX_BLOCKS));
    rem_start_c   = (ADDR_BITS+NeedW)'(cur_q.start) + (ADDR_BITS+NeedW)'(need_q);
    pool_ext_c    = (ADDR_BITS+SizeW)'(pool_q);
    co_e          = rdata_q;
    if (idx_q == fidx_q) begin
      co_e.used = 1'b0;
    end
    merge_c       = !acc_q.used && !co_e.used;
    twice_c       = {req_size_q, 1'b0};
    lim_c         = (max_size_q < init_size_q) ? init_size_q : max_size_q;
    amt_c         = (twice_c > NeedW'(room_q)) ? room_q : twice_c[SizeW-1:0];
    clamp_c       = (cfg_data_i > PoolLimit) ? PoolLimit : cfg_data_i;
    idx_inc       = idx_q + CW'(1);
  end

  // memory write and read address
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[IW-1:0];
    mem_wdata = cur_q;
    mem_raddr = idx_q[IW-1:0];
    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{start: '0, size: init_size_q, used: 1'b0, lg: '0};
      end
      S_SH_RD: begin
        mem_raddr = IW'(k_q - CW'(1));
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[IW-1:0];
        mem_wdata = rdata_q;
      end
      S_WR_REM: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc[IW-1:0];
        mem_wdata = '{start: rem_start_c[ADDR_BITS-1:0],
                      size: cur_q.size - need_q[SizeW-1:0], used: 1'b0, lg: lg_q};
      end
      S_WR_HIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{start: cur_q.start,
                      size: split_q ? need_q[SizeW-1:0] : cur_q.size,
                      used: 1'b1, lg: lg_q};
      end
      S_GROW2: begin
        mem_we    = (req_size_q <= room_q) && (count_q < CW'(MAX_BLOCKS));
        mem_waddr = count_q[IW-1:0];
        mem_wdata = '{start: pool_ext_c[ADDR_BITS-1:0], size: amt_c, used: 1'b0, lg: '0};
      end
      S_CO_EV: begin
        mem_we    = (idx_q != '0) && !merge_c;
        mem_waddr = w_q[IW-1:0];
        mem_wdata = acc_q;
      end
      S_CO_END: begin
        mem_we    = 1'b1;
        mem_waddr = w_q[IW-1:0];
        mem_wdata = acc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      func_q     <= func_i;
      req_size_q <= request_size_i;
      lg_q       <= alignment_log2_i;
      addr_q     <= address_i;
    end
    if (state_q == S_SCAN_EV) begin
      need_q  <= need_c;
      al_q    <= al_full[ADDR_BITS-1:0];
      cur_q   <= rdata_q;
      split_q <= split_c;
    end
    if (state_q == S_GROW1) begin
      room_q <= (lim_c > pool_q) ? lim_c - pool_q : '0;
    end
    if (state_q == S_CO_EV) begin
      if (idx_q == '0 || !merge_c) begin
        acc_q <= co_e;
      end else begin
        acc_q.size <= acc_q.size + co_e.size;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      init_size_q  <= InitSizeRst;
      max_size_q   <= MaxSizeRst;
      margin_q     <= MarginRst;
      pool_q       <= InitSizeRst;
      used_q       <= '0;
      count_q      <= CW'(1);
      idx_q        <= '0;
      k_q          <= '0;
      w_q          <= '0;
      fidx_q       <= '0;
      retry_q      <= 1'b0;
      res_status_q <= ST_OK;
      res_addr_q   <= '0;
      done_o       <= 1'b0;
      address_out_o <= '0;
      status_o     <= ST_OK;
      used_bytes_o <= '0;
      total_bytes_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i && state_q == S_IDLE) begin
        case (cfg_idx_i)
          CfgInitSize: begin
            init_size_q <= (clamp_c == '0) ? size_t'(1) : clamp_c;
            state_q     <= S_INIT;
          end
          CfgMaxSize:     max_size_q <= clamp_c;
          CfgSplitMargin: margin_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (start && !(cfg_we_i && cfg_idx_i == CfgInitSize)) begin
            idx_q      <= '0;
            retry_q    <= 1'b0;
            res_addr_q <= '0;
            if (func_i) begin
              state_q <= S_FIND_RD;
            end else if (request_size_i == '0) begin
              res_status_q <= ST_ALLOC_FAIL;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_INIT: begin
          pool_q  <= init_size_q;
          used_q  <= '0;
          count_q <= CW'(1);
          state_q <= S_IDLE;
        end
        S_SCAN_RD: begin
          if (idx_q >= count_q) begin
            if (retry_q) begin
              res_status_q <= ST_ALLOC_FAIL;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_GROW1;
            end
          end else begin
            state_q <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (fit_c) begin
            k_q <= count_q;
            if (!split_c) begin
              state_q <= S_WR_HIT;
            end else if (count_q == idx_inc) begin
              state_q <= S_WR_REM;
            end else begin
              state_q <= S_SH_RD;
            end
          end else begin
            idx_q   <= idx_inc;
            state_q <= S_SCAN_RD;
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          k_q     <= k_q - CW'(1);
          state_q <= (k_q - CW'(1) == idx_inc) ? S_WR_REM : S_SH_RD;
        end
        S_WR_REM: begin
          count_q <= count_q + CW'(1);
          state_q <= S_WR_HIT;
        end
        S_WR_HIT: begin
          used_q       <= used_q + (split_q ? need_q[SizeW-1:0] : cur_q.size);
          res_status_q <= ST_OK;
          res_addr_q   <= al_q;
          state_q      <= S_DONE;
        end
        S_GROW1: state_q <= S_GROW2;
        S_GROW2: begin
          if (req_size_q > room_q || count_q >= CW'(MAX_BLOCKS)) begin
            res_status_q <= ST_ALLOC_FAIL;
            state_q      <= S_DONE;
          end else begin
            count_q <= count_q + CW'(1);
            pool_q  <= pool_q + amt_c;
            retry_q <= 1'b1;
            idx_q   <= '0;
            state_q <= S_SCAN_RD;
          end
        end
        S_FIND_RD: begin
          if (idx_q >= count_q) begin
            res_status_q <= ST_NOT_FOUND;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_FIND_EV;
          end
        end
        S_FIND_EV: begin
          if (al_full == XW'(addr_q)) begin
            fidx_q <= idx_q;
            if (rdata_q.used) begin
              used_q <= used_q - rdata_q.size;
            end
            idx_q   <= '0;
            w_q     <= '0;
            state_q <= S_CO_RD;
          end else begin
            idx_q   <= idx_inc;
            state_q <= S_FIND_RD;
          end
        end
        S_CO_RD: state_q <= S_CO_EV;
        S_CO_EV: begin
          if (idx_q != '0 && !merge_c) begin
            w_q <= w_q + CW'(1);
          end
          idx_q   <= idx_inc;
          state_q <= (idx_inc >= count_q) ? S_CO_END : S_CO_RD;
        end
        S_CO_END: begin
          count_q      <= w_q + CW'(1);
          res_status_q <= ST_OK;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          done_o        <= 1'b1;
          address_out_o <= (res_status_q == ST_OK && !func_q) ? res_addr_q : '0;
          status_o      <= res_status_q;
          used_bytes_o  <= used_q;
          total_bytes_o <= pool_q;
          state_q       <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire
